FILE: hdl/gsps_pkg.sv
// Shared constants, codes and types of the good-suffix pattern search block.
`default_nettype none
package gsps_pkg;

    localparam int PAT_MAX     = 64;
    localparam int PAT_AW      = $clog2(PAT_MAX);
    localparam int TBL_DEPTH   = PAT_MAX + 1;
    localparam int TBL_AW      = $clog2(TBL_DEPTH);
    localparam int POS_W       = 32;

    // Input command codes
    localparam logic [1:0] CMD_PATTERN = 2'd0;
    localparam logic [1:0] CMD_TEXT    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // Classified operation kinds handed from front to back
    localparam logic [1:0] OP_PATTERN = 2'd0;
    localparam logic [1:0] OP_TEXT    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] symbol;
        logic       last;
    } op_t;

endpackage
`default_nettype wire

FILE: hdl/gsps_front.sv
// Front end: accept requests, classify commands and drop unused ones.
`default_nettype none
module gsps_front (
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [15:0]     s_axis_tdata,   // [1:0] cmd, [9:2] symbol, [15:10] zero
    input  wire logic            s_axis_tlast,   // pattern_last
    output logic                 push,
    output gsps_pkg::op_t        op,
    input  wire logic            q_ready
);

    logic [1:0] cmd;

    assign cmd           = s_axis_tdata[1:0];
    assign s_axis_tready = q_ready;

    // Drop the unused command at the door; everything else goes to the queue.
    assign push = s_axis_tvalid && q_ready && (cmd != gsps_pkg::CMD_NONE);

    always_comb
    begin
        op.symbol = s_axis_tdata[9:2];
        op.last   = s_axis_tlast;
        unique case (cmd)
            gsps_pkg::CMD_PATTERN: op.kind = gsps_pkg::OP_PATTERN;
            gsps_pkg::CMD_TEXT:    op.kind = gsps_pkg::OP_TEXT;
            default:               op.kind = gsps_pkg::OP_RESTART;
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/gsps_queue.sv
// Two-entry queue between the front end and the execution back end.
`default_nettype none
module gsps_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire gsps_pkg::op_t push_op,
    output logic               ready,
    input  wire logic          pop,
    output logic               valid,
    output gsps_pkg::op_t      pop_op
);

    gsps_pkg::op_t slot_reg [2];
    logic          wr_reg;
    logic          wr_next;
    logic          rd_reg;
    logic          rd_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;

    assign ready  = (cnt_reg != 2'd2);
    assign valid  = (cnt_reg != 2'd0);
    assign pop_op = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop  ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/gsps_back.sv
// Back end: pattern load, good-suffix table build, text window compare, result register.
`default_nettype none
module gsps_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    input  wire gsps_pkg::op_t                q_op,
    output logic                              pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [gsps_pkg::POS_W-1:0]        m_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_OUT  = 4'd2;
    localparam logic [3:0] S_PCMP = 4'd3;
    localparam logic [3:0] S_SJ   = 4'd4;
    localparam logic [3:0] S_P2L  = 4'd5;
    localparam logic [3:0] S_P2R  = 4'd6;
    localparam logic [3:0] S_P2W  = 4'd7;
    localparam logic [3:0] S_P2B  = 4'd8;
    localparam logic [3:0] S_CMP  = 4'd9;
    localparam logic [3:0] S_STEP = 4'd10;

    localparam int AW = gsps_pkg::PAT_AW;
    localparam int TW = gsps_pkg::TBL_AW;
    localparam int PW = gsps_pkg::POS_W;
    localparam logic [TW-1:0] LAST_IDX = TW'(gsps_pkg::TBL_DEPTH - 1);
    localparam logic [TW-1:0] ONE      = TW'(1);

    // Storage
    logic [7:0]    pat_mem [gsps_pkg::PAT_MAX];
    logic [7:0]    win_mem [gsps_pkg::PAT_MAX];
    logic [TW-1:0] brd_mem [gsps_pkg::TBL_DEPTH];
    logic [TW-1:0] sft_mem [gsps_pkg::TBL_DEPTH];

    logic [AW-1:0] pa_addr;
    logic [AW-1:0] pb_addr;
    logic [AW-1:0] w_raddr;
    logic [TW-1:0] b_raddr;
    logic [TW-1:0] s_raddr;
    logic [7:0]    pa_q;
    logic [7:0]    pb_q;
    logic [7:0]    w_q;
    logic [TW-1:0] b_q;
    logic [TW-1:0] s_q;

    logic          p_we;
    logic [AW-1:0] p_waddr;
    logic          w_we;
    logic          b_we;
    logic [TW-1:0] b_waddr;
    logic [TW-1:0] b_wdata;
    logic          s_we;
    logic [TW-1:0] s_waddr;
    logic [TW-1:0] s_wdata;

    // Control state
    logic [3:0]    state_reg,   state_next;
    logic [TW-1:0] len_reg,     len_next;
    logic          rdy_reg,     rdy_next;
    logic [PW-1:0] cnt_reg,     cnt_next;
    logic [PW-1:0] aln_reg,     aln_next;
    logic [AW-1:0] head_reg,    head_next;
    logic [TW-1:0] i_reg,       i_next;
    logic [TW-1:0] j_reg,       j_next;
    logic [TW-1:0] k_reg,       k_next;
    logic [TW-1:0] l_reg,       l_next;
    logic [TW-1:0] cj_reg,      cj_next;
    logic          iss_reg,     iss_next;
    logic          pv_reg,      pv_next;
    logic [TW-1:0] dj_reg,      dj_next;
    logic          hit_reg,     hit_next;
    logic [TW-1:0] saddr_reg,   saddr_next;
    logic          ovalid_reg,  ovalid_next;
    logic [PW-1:0] odata_reg,   odata_next;

    logic [TW-1:0] len_eff;
    logic [PW-1:0] cnt_inc;
    logic [TW-1:0] step;
    logic          can_emit;

    assign m_valid = ovalid_reg;
    assign m_data  = odata_reg;
    assign pop     = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        len_eff  = rdy_reg ? '0 : len_reg;
        cnt_inc  = cnt_reg + PW'(1);
        step     = (s_q == '0) ? ONE : s_q;
        can_emit = !ovalid_reg || m_ready;

        state_next  = state_reg;
        len_next    = len_reg;
        rdy_next    = rdy_reg;
        cnt_next    = cnt_reg;
        aln_next    = aln_reg;
        head_next   = head_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        l_next      = l_reg;
        cj_next     = cj_reg;
        iss_next    = iss_reg;
        pv_next     = 1'b0;
        dj_next     = dj_reg;
        hit_next    = hit_reg;
        saddr_next  = saddr_reg;
        ovalid_next = ovalid_reg && !m_ready;
        odata_next  = odata_reg;

        pa_addr = '0;
        pb_addr = '0;
        w_raddr = '0;
        b_raddr = '0;
        s_raddr = saddr_reg;
        p_we    = 1'b0;
        p_waddr = len_eff[AW-1:0];
        w_we    = 1'b0;
        b_we    = 1'b0;
        b_waddr = i_reg - ONE;
        b_wdata = j_reg - ONE;
        s_we    = 1'b0;
        s_waddr = k_reg;
        s_wdata = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_op.kind)
                        gsps_pkg::OP_PATTERN:
                        begin
                            rdy_next = 1'b0;
                            len_next = len_eff;
                            if (len_eff < LAST_IDX)
                            begin
                                p_we     = 1'b1;
                                len_next = len_eff + ONE;
                            end
                            if (q_op.last)
                            begin
                                cnt_next   = '0;
                                aln_next   = '0;
                                head_next  = '0;
                                k_next     = '0;
                                state_next = S_CLR;
                            end
                        end
                        gsps_pkg::OP_TEXT:
                        begin
                            if (rdy_reg)
                            begin
                                w_we      = 1'b1;
                                head_next = head_reg + AW'(1);
                                cnt_next  = cnt_inc;
                                if ((cnt_inc - aln_reg) == PW'(len_reg))
                                begin
                                    cj_next    = len_reg - ONE;
                                    iss_next   = 1'b1;
                                    state_next = S_CMP;
                                end
                            end
                        end
                        default:
                        begin
                            cnt_next  = '0;
                            aln_next  = '0;
                            head_next = '0;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                s_we = 1'b1;
                if (k_reg == LAST_IDX)
                begin
                    b_we       = 1'b1;
                    b_waddr    = len_reg;
                    b_wdata    = len_reg + ONE;
                    i_next     = len_reg;
                    j_next     = len_reg + ONE;
                    state_next = S_OUT;
                end
                else
                begin
                    k_next = k_reg + ONE;
                end
            end
            S_OUT:
            begin
                if (i_reg == '0)
                begin
                    b_raddr    = '0;
                    state_next = S_P2L;
                end
                else if ((j_reg != '0) && (j_reg <= len_reg))
                begin
                    pa_addr    = AW'(i_reg - ONE);
                    pb_addr    = AW'(j_reg - ONE);
                    state_next = S_PCMP;
                end
                else
                begin
                    b_we   = 1'b1;
                    i_next = i_reg - ONE;
                    j_next = j_reg - ONE;
                end
            end
            S_PCMP:
            begin
                if (pa_q != pb_q)
                begin
                    b_raddr    = j_reg;
                    s_raddr    = j_reg;
                    state_next = S_SJ;
                end
                else
                begin
                    b_we       = 1'b1;
                    i_next     = i_reg - ONE;
                    j_next     = j_reg - ONE;
                    state_next = S_OUT;
                end
            end
            S_SJ:
            begin
                if (s_q == '0)
                begin
                    s_we    = 1'b1;
                    s_waddr = j_reg;
                    s_wdata = j_reg - i_reg;
                end
                j_next     = b_q;
                state_next = S_OUT;
            end
            S_P2L:
            begin
                l_next     = b_q;
                k_next     = '0;
                state_next = S_P2R;
            end
            S_P2R:
            begin
                s_raddr    = k_reg;
                state_next = S_P2W;
            end
            S_P2W, S_P2B:
            begin
                if ((state_reg == S_P2W) && (s_q == '0))
                begin
                    s_we    = 1'b1;
                    s_wdata = l_reg;
                end
                if ((state_reg == S_P2W) && (k_reg == l_reg))
                begin
                    // Follow the border chain; an index past the table folds to zero.
                    b_raddr    = (l_reg > LAST_IDX) ? '0 : l_reg;
                    state_next = S_P2B;
                end
                else
                begin
                    if (state_reg == S_P2B)
                    begin
                        l_next = b_q;
                    end
                    if (k_reg == len_reg)
                    begin
                        rdy_next   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + ONE;
                        state_next = S_P2R;
                    end
                end
            end
            S_CMP:
            begin
                // Issue one pattern/window pair per cycle, compare it the cycle after.
                pa_addr = AW'(cj_reg);
                w_raddr = AW'(TW'(head_reg) + cj_reg - len_reg);
                if (iss_reg)
                begin
                    pv_next = 1'b1;
                    dj_next = cj_reg;
                    if (cj_reg == '0)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        cj_next = cj_reg - ONE;
                    end
                end
                if (pv_reg)
                begin
                    if (pa_q != w_q)
                    begin
                        hit_next   = 1'b0;
                        saddr_next = dj_reg + ONE;
                        s_raddr    = dj_reg + ONE;
                        iss_next   = 1'b0;
                        pv_next    = 1'b0;
                        state_next = S_STEP;
                    end
                    else if (dj_reg == '0)
                    begin
                        hit_next   = 1'b1;
                        saddr_next = '0;
                        s_raddr    = '0;
                        pv_next    = 1'b0;
                        state_next = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                if (!hit_reg || can_emit)
                begin
                    if (hit_reg)
                    begin
                        ovalid_next = 1'b1;
                        odata_next  = aln_reg;
                    end
                    aln_next   = aln_reg + PW'(step);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pat_mem[p_waddr] <= q_op.symbol;
        end
        if (w_we)
        begin
            win_mem[head_reg] <= q_op.symbol;
        end
        if (b_we)
        begin
            brd_mem[b_waddr] <= b_wdata;
        end
        if (s_we)
        begin
            sft_mem[s_waddr] <= s_wdata;
        end
        pa_q <= pat_mem[pa_addr];
        pb_q <= pat_mem[pb_addr];
        w_q  <= win_mem[w_raddr];
        b_q  <= brd_mem[b_raddr];
        s_q  <= sft_mem[s_raddr];
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        l_reg     <= l_next;
        cj_reg    <= cj_next;
        dj_reg    <= dj_next;
        hit_reg   <= hit_next;
        saddr_reg <= saddr_next;
        odata_reg <= odata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            rdy_reg    <= 1'b0;
            cnt_reg    <= '0;
            aln_reg    <= '0;
            head_reg   <= '0;
            iss_reg    <= 1'b0;
            pv_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            rdy_reg    <= rdy_next;
            cnt_reg    <= cnt_next;
            aln_reg    <= aln_next;
            head_reg   <= head_next;
            iss_reg    <= iss_next;
            pv_reg     <= pv_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/good_suffix_pattern_search.sv
// Top level of the streaming good-suffix pattern search.
//
//  Channel   Direction  Handshake                  Carries
//  s_axis    in         s_axis_tvalid/tready       cmd, symbol (tdata), pattern_last (tlast)
//  m_axis    out        m_axis_tvalid/tready       match_position (tdata)
//
// Restart, non-completing text and non-final pattern requests are handled in the idle state.
// A final pattern byte builds the tables: it clears all 65 shift-table entries, then runs
// the border pass and then the shift pass (one read port per table).
// A completing text byte compares one byte per cycle, right to left, then steps the alignment.
// Reset clears state, length, counters, issue flags and output valid; the other registers and
// the memories hold garbage until written. A two-entry queue keeps accepting while the back end
// works, until it is full; a match stalls only on a previous result still waiting on m_axis_tready.
`default_nettype none
module good_suffix_pattern_search (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [1:0] cmd, [9:2] symbol, [15:10] zero
    input  wire logic        s_axis_tlast,   // pattern_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] match_position
);

    logic          push;
    logic          q_ready;
    logic          q_valid;
    logic          pop;
    gsps_pkg::op_t front_op;
    gsps_pkg::op_t back_op;

    // Classify incoming requests; drop unused commands.
    gsps_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push          (push),
        .op            (front_op),
        .q_ready       (q_ready)
    );

    // Hold up to two classified requests between the two halves.
    gsps_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (front_op),
        .ready   (q_ready),
        .pop     (pop),
        .valid   (q_valid),
        .pop_op  (back_op)
    );

    // Execute: load, build tables, scan text, emit matches.
    gsps_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_op    (back_op),
        .pop     (pop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

FILE: hdl/gsps_checker.sv
// Port-level checker for the good-suffix pattern search, bound to the top level.
`default_nettype none
module gsps_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [15:0] s_axis_tdata,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The queue only fills on an accepted request.
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("input ready dropped without a request");

    // No result leaves right out of reset.
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind good_suffix_pattern_search gsps_checker u_gsps_checker (.*);
`default_nettype wire
